FILE: hdl/ibfr_pkg.sv
// Package for the frame receiver: payload types, constants, register map and control types.
`timescale 1ns / 1ps
`default_nettype none
package ibfr_pkg;

  localparam int CHANNELS = 14;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W    = 6;

  localparam logic [CNT_W-1:0] FRAME_LEN = CNT_W'(2 * CHANNELS + 4);
  localparam logic [CNT_W-1:0] CSUM_POS  = CNT_W'(2 * CHANNELS + 2);
  localparam logic [CNT_W-1:0] DATA_POS  = CNT_W'(2);
  localparam logic [CH_W-1:0]  LAST_CH   = CH_W'(CHANNELS - 1);

  localparam logic [15:0] OVERRUN_GAP  = 16'hFFFE;
  localparam logic [15:0] SUM_INIT     = 16'hFFFF;

  localparam logic [7:0]  HEADER_RST   = 8'h20;
  localparam logic [15:0] GAP_RST      = 16'd21000;
  localparam logic [15:0] SWITCH_RST   = 16'd1600;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_HEADER,
    REG_GAP,
    REG_SWITCH
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [15:0] gap_ticks;
    logic        overrun;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        switch_on;
    logic        frame_ok;
    logic        last;
  } out_req_t;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [15:0] gap_threshold;
    logic [15:0] switch_threshold;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_EMIT,
    ST_ERROR
  } state_e;

  typedef struct packed {
    logic            hold;
    logic            load;
    logic            err;
    logic [CH_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic done_ok;
    logic done_err;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: hdl/ibfr_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module ibfr_regs
  import ibfr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte      <= HEADER_RST;
      cfg_q.gap_threshold    <= GAP_RST;
      cfg_q.switch_threshold <= SWITCH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HEADER: cfg_q.header_byte      <= pwdata[7:0];
        REG_GAP:    cfg_q.gap_threshold    <= pwdata[15:0];
        REG_SWITCH: cfg_q.switch_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEADER: prdata = {24'b0, cfg_q.header_byte};
      REG_GAP:    prdata = {16'b0, cfg_q.gap_threshold};
      REG_SWITCH: prdata = {16'b0, cfg_q.switch_threshold};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: hdl/ibfr_ctrl.sv
// Controller: frame sequencing and result emission state machine.
`timescale 1ns / 1ps
`default_nettype none
module ibfr_ctrl
  import ibfr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e          state_q, state_d;
  logic [CH_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RECV;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.hold = 1'b1;
    cmd_o.load = 1'b0;
    cmd_o.err  = 1'b0;
    cmd_o.idx  = cnt_q;
    unique case (state_q)
      ST_RECV: begin
        cmd_o.hold = 1'b0;
        cnt_d      = '0;
        if (status_i.done_ok) begin
          state_d = ST_EMIT;
        end else if (status_i.done_err) begin
          state_d = ST_ERROR;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          if (cnt_q == LAST_CH) begin
            state_d = ST_RECV;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_ERROR: begin
        cmd_o.err = 1'b1;
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RECV;
        end
      end
      default: begin
        state_d = ST_RECV;
        cnt_d   = '0;
      end
    endcase
  end

`ifndef SYNTH
  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> status_i.out_free)
    else $error("result loaded while output register busy");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> cnt_q <= LAST_CH)
    else $error("emit counter out of range");

  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_RECV |-> !status_i.done_ok && !status_i.done_err)
    else $error("frame completed while emitting");

  a_emit_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && cmd_o.load && cnt_q == LAST_CH |=> state_q == ST_RECV)
    else $error("emission did not end after last channel");
`endif

endmodule
`default_nettype wire

FILE: hdl/ibfr_dp.sv
// Datapath: frame parsing, checksum, channel store and output register.
`timescale 1ns / 1ps
`default_nettype none
module ibfr_dp
  import ibfr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire logic    in_valid_i,
  input  wire in_req_t in_data_i,
  input  wire logic    out_stall_i,
  input  wire cmd_t    cmd_i,
  output status_t      status_o,
  output logic         out_valid_o,
  output out_req_t     out_data_o
);

  logic             in_frame_q;
  logic [CNT_W-1:0] count_q;
  logic [15:0]      sum_q;
  logic [7:0]       csum_low_q;
  logic [7:0]       low_hold_q;
  logic [15:0]      store_q [CHANNELS];
  logic             out_valid_q;
  out_req_t         out_q;

  logic             accept;
  logic [15:0]      eff_gap;
  logic             start;
  logic             frame_byte;
  logic [CNT_W-1:0] idx_m2;
  logic [CH_W-1:0]  ch;
  logic             store_we;
  logic [15:0]      received;
  logic             final_byte;
  logic             csum_good;
  logic [15:0]      rd_val;

  assign accept     = in_valid_i && !cmd_i.hold;
  assign eff_gap    = in_data_i.overrun ? OVERRUN_GAP : in_data_i.gap_ticks;
  assign start      = accept && (in_data_i.rx_byte == cfg_i.header_byte)
                      && (eff_gap > cfg_i.gap_threshold);
  assign frame_byte = accept && !start && in_frame_q;
  assign idx_m2     = count_q - DATA_POS;
  assign ch         = idx_m2[CH_W:1];
  assign store_we   = frame_byte && (count_q < CSUM_POS) && (count_q >= DATA_POS)
                      && count_q[0] && (ch <= LAST_CH);
  assign received   = {in_data_i.rx_byte, csum_low_q};
  assign final_byte = frame_byte && (count_q > CSUM_POS);
  assign csum_good  = (count_q == FRAME_LEN - 1'b1) && (received == sum_q);

  assign status_o.done_ok  = final_byte && csum_good;
  assign status_o.done_err = final_byte && !csum_good;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      sum_q      <= SUM_INIT;
    end else if (start) begin
      in_frame_q <= 1'b1;
      count_q    <= CNT_W'(1);
      sum_q      <= SUM_INIT - {8'b0, in_data_i.rx_byte};
    end else if (frame_byte) begin
      count_q <= count_q + 1'b1;
      if (count_q < CSUM_POS) begin
        sum_q <= sum_q - {8'b0, in_data_i.rx_byte};
      end else if (count_q > CSUM_POS) begin
        in_frame_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_byte && count_q == CSUM_POS) begin
      csum_low_q <= in_data_i.rx_byte;
    end
    if (frame_byte && count_q < CSUM_POS && count_q >= DATA_POS && !count_q[0]) begin
      low_hold_q <= in_data_i.rx_byte;
    end
    if (store_we) begin
      store_q[ch] <= {in_data_i.rx_byte, low_hold_q};
    end
  end

  assign rd_val = store_q[cmd_i.idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (cmd_i.err) begin
        out_q <= '{channel_index: '0, channel_value: '0, switch_on: 1'b0,
                   frame_ok: 1'b0, last: 1'b1};
      end else begin
        out_q.channel_index <= 4'(cmd_i.idx);
        out_q.channel_value <= rd_val;
        out_q.switch_on     <= rd_val > cfg_i.switch_threshold;
        out_q.frame_ok      <= 1'b1;
        out_q.last          <= cmd_i.idx == LAST_CH;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: hdl/ibus_frame_receiver.sv
// Top level: serial frame receiver with checksum check and per-channel results.
// Input bytes are taken one per cycle while a frame is received.
// After the final byte, the controller state and then the output register update; results
// follow one per cycle, 14 for a good frame or one error result; input is stalled meanwhile.
// The output register holds a result until taken; a stalled output stretches emission.
// Reset clears frame state, emission state and output valid; config registers take defaults.
`timescale 1ns / 1ps
`default_nettype none
module ibus_frame_receiver
  import ibfr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire in_req_t           in_data_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output out_req_t               out_data_o,
  input  wire logic              out_stall_i,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  ibfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ibfr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ibfr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = cmd.hold;

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Testbench for the frame receiver: frame stimulus, channel prediction and result checks.
`timescale 1ns / 1ps
module tb;
  import ibfr_pkg::*;

  localparam int FRAME_BYTES  = 2 * CHANNELS + 4;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;

  typedef enum int {
    FR_GOOD,
    FR_EXTREME,
    FR_BAD_SUM,
    FR_OVERRUN,
    FR_TRUNCATED
  } frame_kind_e;

  class channel_scoreboard;
    logic [7:0]  header;
    logic [15:0] gap_thr;
    logic [15:0] switch_thr;
    bit          framing;
    logic [5:0]  pos;
    logic [15:0] csum_acc;
    logic [7:0]  csum_lo;
    logic [7:0]  word_lo;
    logic [15:0] chan_words[CHANNELS];
    out_req_t    expected_channels[$];
    int          mismatches;

    function new();
      header     = HEADER_RST;
      gap_thr    = GAP_RST;
      switch_thr = SWITCH_RST;
      framing    = 1'b0;
      pos        = '0;
      csum_acc   = SUM_INIT;
      csum_lo    = '0;
      word_lo    = '0;
      foreach (chan_words[i]) chan_words[i] = '0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e r, logic [31:0] v);
      case (r)
        REG_HEADER: header = v[7:0];
        REG_GAP:    gap_thr = v[15:0];
        REG_SWITCH: switch_thr = v[15:0];
        default: ;
      endcase
    endfunction

    function void note_byte(in_req_t r);
      logic [15:0] eff_gap;
      logic [5:0]  at;
      out_req_t    res;
      eff_gap = r.overrun ? OVERRUN_GAP : r.gap_ticks;
      if (r.rx_byte == header && eff_gap > gap_thr) begin
        framing  = 1'b1;
        pos      = 6'd1;
        csum_acc = SUM_INIT - 16'(r.rx_byte);
        return;
      end
      if (!framing) return;
      at  = pos;
      pos = pos + 6'd1;
      if (at < CSUM_POS) begin
        csum_acc = csum_acc - 16'(r.rx_byte);
        if (at >= DATA_POS) begin
          if (!at[0]) word_lo = r.rx_byte;
          else chan_words[(at - DATA_POS) >> 1] = {r.rx_byte, word_lo};
        end
      end else if (at == CSUM_POS) begin
        csum_lo = r.rx_byte;
      end else begin
        framing = 1'b0;
        if (at != FRAME_LEN - 6'd1 || {r.rx_byte, csum_lo} != csum_acc) begin
          res      = '0;
          res.last = 1'b1;
          expected_channels.push_back(res);
        end else begin
          for (int k = 0; k < CHANNELS; k++) begin
            res.channel_index = 4'(k);
            res.channel_value = chan_words[k];
            res.switch_on     = chan_words[k] > switch_thr;
            res.frame_ok      = 1'b1;
            res.last          = (k == CHANNELS - 1);
            expected_channels.push_back(res);
          end
        end
      end
    endfunction

    function void check_channel(out_req_t got);
      out_req_t exp;
      if (expected_channels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected result idx=%0d val=%h sw=%0b ok=%0b last=%0b",
                   got.channel_index, got.channel_value, got.switch_on, got.frame_ok,
                   got.last);
        return;
      end
      exp = expected_channels.pop_front();
      if (got.channel_index !== exp.channel_index || got.channel_value !== exp.channel_value ||
          got.switch_on !== exp.switch_on || got.frame_ok !== exp.frame_ok ||
          got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: expected idx=%0d val=%h sw=%0b ok=%0b last=%0b, got idx=%0d val=%h sw=%0b ok=%0b last=%0b",
                   exp.channel_index, exp.channel_value, exp.switch_on, exp.frame_ok, exp.last,
                   got.channel_index, got.channel_value, got.switch_on, got.frame_ok, got.last);
      end
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  in_req_t           in_data   = '0;
  logic              in_stall;
  logic              out_valid;
  out_req_t          out_data;
  logic              out_stall = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int send_idle_pct = 0;
  int out_stall_pct = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  channel_scoreboard sb = new();

  ibus_frame_receiver uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_stall_i (out_stall),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // result monitor and no-progress watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_channel(out_data);
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no request moved for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(in_req_t r);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    sb.note_byte(r);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_channels.size() != 0);
  endtask

  task automatic settle();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(r));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(r, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [7:0] h, logic [15:0] g, logic [15:0] s);
    settle();
    write_reg(REG_HEADER, 32'(h));
    write_reg(REG_GAP, 32'(g));
    write_reg(REG_SWITCH, 32'(s));
  endtask

  function automatic in_req_t header_req(bit ovr);
    in_req_t r;
    r.rx_byte = sb.header;
    r.overrun = 1'b0;
    if (ovr && sb.gap_thr < OVERRUN_GAP) begin
      r.overrun   = 1'b1;
      r.gap_ticks = 16'($urandom);
    end else if (sb.gap_thr == 16'hFFFF) begin
      r.gap_ticks = 16'hFFFF;
    end else begin
      r.gap_ticks = 16'($urandom_range(65535, int'(sb.gap_thr) + 1));
    end
    return r;
  endfunction

  // a data byte equal to the header keeps its gap at or below the threshold
  function automatic in_req_t data_req(logic [7:0] b);
    in_req_t r;
    r.rx_byte   = b;
    r.overrun   = 1'b0;
    r.gap_ticks = (b == sb.header) ? 16'($urandom_range(int'(sb.gap_thr), 0))
                                   : 16'($urandom);
    return r;
  endfunction

  function automatic logic [15:0] channel_pick(int ch, bit extreme);
    int sel;
    sel = extreme ? ch : $urandom_range(11);
    case (sel)
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return sb.switch_thr;
      3:       return sb.switch_thr + 16'd1;
      4:       return sb.switch_thr - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(frame_kind_e kind, bit ovr_start);
    logic [7:0]  b[FRAME_BYTES];
    logic [15:0] acc;
    logic [15:0] v;
    in_req_t     req;
    int          stop;
    int          hit;
    b[0] = sb.header;
    b[1] = 8'($urandom);
    for (int ch = 0; ch < CHANNELS; ch++) begin
      v             = channel_pick(ch, kind == FR_EXTREME);
      b[2 + 2 * ch] = v[7:0];
      b[3 + 2 * ch] = v[15:8];
    end
    acc = SUM_INIT;
    for (int i = 0; i < FRAME_BYTES - 2; i++) acc = acc - 16'(b[i]);
    b[FRAME_BYTES - 2] = acc[7:0];
    b[FRAME_BYTES - 1] = acc[15:8];
    if (kind == FR_BAD_SUM)
      b[FRAME_BYTES - 2 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
    stop = (kind == FR_TRUNCATED) ? $urandom_range(FRAME_BYTES - 1, 1) : FRAME_BYTES;
    hit  = (kind == FR_OVERRUN) ? $urandom_range(FRAME_BYTES - 1, 1) : 0;
    send_byte(header_req(ovr_start));
    for (int i = 1; i < stop; i++) begin
      req = data_req(b[i]);
      if (i == hit) begin
        req.overrun = 1'b1;
        if ($urandom_range(1)) req.rx_byte = 8'($urandom);
      end
      send_byte(req);
    end
  endtask

  task automatic run_random(int count);
    int      target;
    int      pick;
    bit      ovr;
    in_req_t noise;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(15) == 0) wait_drain();
      pick = $urandom_range(99);
      ovr  = ($urandom_range(3) == 0);
      if (pick < 55) begin
        send_frame(FR_GOOD, ovr);
      end else if (pick < 62) begin
        send_frame(FR_EXTREME, ovr);
      end else if (pick < 72) begin
        send_frame(FR_BAD_SUM, ovr);
      end else if (pick < 82) begin
        send_frame(FR_OVERRUN, ovr);
      end else if (pick < 92) begin
        send_frame(FR_TRUNCATED, ovr);
      end else begin
        repeat ($urandom_range(4, 1)) begin
          noise = 25'($urandom);
          send_byte(noise);
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: gap equal to the threshold does not open a frame
    send_byte({HEADER_RST, GAP_RST, 1'b0});
    send_byte({8'h55, 16'hFFFF, 1'b1});
    send_frame(FR_EXTREME, 1'b1);
    send_frame(FR_BAD_SUM, 1'b0);

    configure(8'hFF, 16'h0000, 16'h0000);
    send_idle_pct = 79;
    run_random(75);

    send_idle_pct = 0;
    configure(8'h00, 16'hFFFE, 16'hFFFF);
    out_stall_pct = 79;
    send_byte({8'h00, 16'h0000, 1'b1});
    run_random(75);

    configure(8'($urandom), 16'($urandom_range(60000)), 16'($urandom));
    send_idle_pct = 12;
    out_stall_pct = 12;
    run_random(75);

    // no gap can exceed an all-ones threshold
    settle();
    write_reg(REG_GAP, 32'hFFFF);
    send_byte({sb.header, 16'hFFFF, 1'b0});
    send_byte({sb.header, 16'hFFFF, 1'b1});
    send_byte({sb.header, 16'h1234, 1'b1});

    send_idle_pct = 0;
    out_stall_pct = 0;
    configure(8'h20, 16'd21000, 16'd1600);
    run_random(60);

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_channels.size() != 0) begin
      sb.mismatches++;
      $display("ERROR: %0d expected results never arrived", sb.expected_channels.size());
    end
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/ibfr_pkg.sv
hdl/ibfr_regs.sv
hdl/ibfr_ctrl.sv
hdl/ibfr_dp.sv
hdl/ibus_frame_receiver.sv
bench/tb.sv
